@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file itf_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ src/itf_pkg.sv @@
// ----------------------------------------------------------------------------
// itf_pkg
// Types and constants shared by the integer to text formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int unsigned FlagZero   = 0;
  localparam int unsigned FlagSigned = 1;
  localparam int unsigned FlagPlus   = 2;
  localparam int unsigned FlagSpace  = 3;
  localparam int unsigned FlagLeft   = 4;
  localparam int unsigned FlagPrefix = 5;
  localparam int unsigned FlagLower  = 6;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChZero  = 8'h30;

  localparam logic [5:0] RadixOct = 6'd8;
  localparam logic [5:0] RadixHex = 6'd16;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic        bad;
    logic [63:0] mag;
    logic [5:0]  radix;
    logic [5:0]  width;
    logic [5:0]  prec;
    logic [7:0]  sign;    // zero when no sign character
    logic        zero;
    logic        left;
    logic        prefix;
    logic        lower;
  } itf_job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_PAD, ST_SIGN, ST_PRE0, ST_PREX,
    ST_ZPAD, ST_PZERO, ST_DIGIT, ST_TAIL, ST_BAD
  } itf_state_e;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
    logic [7:0] c;
    if (d < 6'd10) c = 8'h30 + {2'b00, d};
    else if (lower) c = 8'h61 + {2'b00, d} - 8'd10;
    else c = 8'h41 + {2'b00, d} - 8'd10;
    return c;
  endfunction

endpackage

@@ src/integer_to_text_formatter.sv @@
// ----------------------------------------------------------------------------
// integer_to_text_formatter
// printf-style integer to ASCII text, one character per output item.
// ----------------------------------------------------------------------------
// Each input item carries an integer, a base (2..36), field width, minimum
// digit count and flags; the block emits the formatted text one character
// per output item, last set on the final one. A base outside 2..36 gives a
// single item with bad_base set and character 0. Text is capped at
// MAX_CHARS characters, the final item then flagged truncated.
// Flow: a front stage classifies an item into a one-entry queue. The
// back takes a job, then extracts digits with a restoring divider, one
// quotient bit per cycle. A sizing step then works out the padding; after
// that the text streams at one character per cycle while the receiver is
// ready, and each of the five runs (leading spaces, zero padding,
// precision zeros, digits, trailing spaces) ends in a step that emits
// nothing, as does each of the three sign and prefix slots left empty.
// Once MAX_CHARS characters are out the rest is dropped at once. A stalled
// receiver holds the back on any character it has to emit. The back takes
// one item at a time; the queue lets the next item be accepted while the
// current one is still being processed.
module integer_to_text_formatter import itf_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_CHARS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] value_i,
  input  logic [5:0]  radix_i,
  input  logic [5:0]  field_width_i,
  input  logic [5:0]  min_digits_i,
  input  logic [6:0]  format_flags_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_o,
  output logic        bad_base_o,
  output logic        truncated_o
);

  logic     job_valid, job_ready;
  itf_job_t job;

  itf_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .value_i, .radix_i, .field_width_i,
    .min_digits_i, .format_flags_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  itf_back #(.VALUE_BITS(VALUE_BITS), .MAX_CHARS(MAX_CHARS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .valid_o, .ready_i, .out_char_o, .last_o, .bad_base_o,
    .truncated_o
  );

endmodule

@@ src/itf_front.sv @@
// ----------------------------------------------------------------------------
// itf_front
// Accept an item, classify sign, magnitude and base into a job.
// ----------------------------------------------------------------------------
module itf_front import itf_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] value_i,
  input  logic [5:0]  radix_i,
  input  logic [5:0]  field_width_i,
  input  logic [5:0]  min_digits_i,
  input  logic [6:0]  format_flags_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output itf_job_t    job_o
);

  localparam logic [63:0] ValueMask = {64{1'b1}} >> (64 - VALUE_BITS);

  logic [63:0] raw, mag;
  logic        neg;
  itf_job_t    job_d, job_q;
  logic        full_q;

  always_comb begin
    raw = {32'h0, value_i} & ValueMask;
    neg = format_flags_i[FlagSigned] & raw[VALUE_BITS-1];
    mag = neg ? ((~raw + 64'd1) & ValueMask) : raw;
    job_d.bad    = (radix_i < 6'd2) || (radix_i > 6'd36);
    job_d.mag    = mag;
    job_d.radix  = radix_i;
    job_d.width  = field_width_i;
    job_d.prec   = min_digits_i;
    job_d.left   = format_flags_i[FlagLeft];
    job_d.zero   = format_flags_i[FlagZero] & ~format_flags_i[FlagLeft];
    job_d.prefix = format_flags_i[FlagPrefix];
    job_d.lower  = format_flags_i[FlagLower];
    if (neg) job_d.sign = ChMinus;
    else if (format_flags_i[FlagPlus]) job_d.sign = ChPlus;
    else if (format_flags_i[FlagSpace]) job_d.sign = ChSpace;
    else job_d.sign = 8'h00;
  end

  // One-entry queue towards the back.
  assign ready_o     = ~full_q | job_ready_i;
  assign job_valid_o = full_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (ready_o) begin
      full_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) job_q <= job_d;
  end

endmodule

@@ src/itf_back.sv @@
// ----------------------------------------------------------------------------
// itf_back
// Extract digits by serial division, then stream the text one item a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module itf_back import itf_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_CHARS  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  itf_job_t   job_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_char_o,
  output logic       last_o,
  output logic       bad_base_o,
  output logic       truncated_o
);

  localparam int unsigned BitW      = $clog2(VALUE_BITS + 1);
  localparam int unsigned MaxDigits = 64;

  itf_state_e state_q, state_d;
  itf_job_t   job_q;
  logic [5:0] digs_q [MaxDigits]; // digit stack, most significant at index 0
  logic [6:0] nd_q, nd_d;
  logic [63:0] quo_q, quo_d;
  logic [5:0]  rem_q, rem_d;
  logic [BitW-1:0] bit_q, bit_d;
  logic [7:0]  pad_q, pad_d;     // remaining width, unsigned 8 bit
  logic [6:0]  cnt_q, cnt_d;     // run counter
  logic [6:0]  emit_q, emit_d;   // chars emitted so far
  logic [6:0]  tot_q, tot_d;     // total text length (saturates at 127)
  logic [7:0]  tot_full;
  logic        dig_we;
  logic        dig_pop;
  logic [5:0]  dig_val;
  logic [6:0]  rem_sh;
  logic [7:0]  ch;
  logic        ch_v;
  logic        take_job;
  logic [5:0]  prec_eff;
  logic        obuf_v_q;
  logic [7:0]  obuf_c_q;
  logic        obuf_l_q, obuf_b_q, obuf_t_q;
  logic        can_emit;

  assign can_emit = ~obuf_v_q | ready_i;
  assign job_ready_o = (state_q == ST_IDLE);
  assign take_job = job_valid_i && job_ready_o;
  assign prec_eff = (nd_q > {1'b0, job_q.prec}) ? nd_q[5:0] : job_q.prec;

  // Total length of the text once digits are known.
  always_comb begin
    logic [7:0] body;
    logic [7:0] w;
    body = {2'b00, prec_eff} + ((job_q.sign != 8'h00) ? 8'd1 : 8'd0);
    if (job_q.prefix && job_q.radix == RadixHex) body = body + 8'd2;
    else if (job_q.prefix && job_q.radix == RadixOct) body = body + 8'd1;
    w = {2'b00, job_q.width};
    tot_full = ($signed(w) > $signed(body)) ? w : body;
  end

  always_comb begin
    state_d = state_q;
    nd_d    = nd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    pad_d   = pad_q;
    cnt_d   = cnt_q;
    emit_d  = emit_q;
    tot_d   = tot_q;
    dig_we  = 1'b0;
    dig_pop = 1'b0;
    dig_val = '0;
    ch      = 8'h00;
    ch_v    = 1'b0;
    rem_sh  = {rem_q, quo_q[bit_q]};
    unique case (state_q)
      ST_IDLE: begin
        if (take_job) begin
          nd_d  = '0;
          quo_d = job_i.mag;
          rem_d = '0;
          bit_d = BitW'(VALUE_BITS - 1);
          emit_d = '0;
          state_d = job_i.bad ? ST_BAD : ST_DIV;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle.
        if (rem_sh >= {1'b0, job_q.radix}) begin
          rem_d = 6'(rem_sh - {1'b0, job_q.radix});
          quo_d[bit_q] = 1'b1;
        end else begin
          rem_d = rem_sh[5:0];
          quo_d[bit_q] = 1'b0;
        end
        if (bit_q == '0) begin
          dig_we = 1'b1;
          dig_val = rem_d;
          nd_d = nd_q + 7'd1;
          rem_d = '0;
          bit_d = BitW'(VALUE_BITS - 1);
          if (quo_d == '0) begin
            state_d = ST_PAD;
            pad_d = 8'hff; // marks "compute on entry"
          end
        end else begin
          bit_d = bit_q - BitW'(1);
        end
      end
      ST_PAD: begin
        if (pad_q == 8'hff) begin
          tot_d = (tot_full > 8'd127) ? 7'd127 : tot_full[6:0];
          pad_d = tot_full - ({2'b00, prec_eff}
                  + ((job_q.sign != 8'h00) ? 8'd1 : 8'd0)
                  + ((job_q.prefix && job_q.radix == RadixHex) ? 8'd2 :
                     (job_q.prefix && job_q.radix == RadixOct) ? 8'd1 : 8'd0));
          cnt_d = pad_d[6:0];
          if (job_q.zero || job_q.left) cnt_d = '0;
        end else if (cnt_q != '0) begin
          ch = ChSpace; ch_v = 1'b1;
          if (can_emit) cnt_d = cnt_q - 7'd1;
        end else begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (job_q.sign != 8'h00) begin
          ch = job_q.sign; ch_v = 1'b1;
        end
        if (can_emit || job_q.sign == 8'h00) state_d = ST_PRE0;
      end
      ST_PRE0: begin
        if (job_q.prefix && (job_q.radix == RadixHex || job_q.radix == RadixOct)) begin
          ch = ChZero; ch_v = 1'b1;
          if (can_emit) state_d = ST_PREX;
        end else begin
          state_d = ST_PREX;
        end
        cnt_d = job_q.zero ? pad_q[6:0] : 7'd0;
      end
      ST_PREX: begin
        if (job_q.prefix && job_q.radix == RadixHex) begin
          ch = job_q.lower ? 8'h78 : 8'h58; ch_v = 1'b1;
          if (can_emit) state_d = ST_ZPAD;
        end else begin
          state_d = ST_ZPAD;
        end
      end
      ST_ZPAD: begin
        if (cnt_q != '0) begin
          ch = ChZero; ch_v = 1'b1;
          if (can_emit) cnt_d = cnt_q - 7'd1;
        end else begin
          cnt_d = 7'({1'b0, prec_eff} - nd_q);
          state_d = ST_PZERO;
        end
      end
      ST_PZERO: begin
        if (cnt_q != '0) begin
          ch = ChZero; ch_v = 1'b1;
          if (can_emit) cnt_d = cnt_q - 7'd1;
        end else begin
          cnt_d = nd_q;
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        // Pop the stack: the most significant digit sits on top.
        if (cnt_q != '0) begin
          ch = digit_char(digs_q[0], job_q.lower); ch_v = 1'b1;
          if (can_emit) begin
            cnt_d = cnt_q - 7'd1;
            dig_pop = 1'b1;
          end
        end else begin
          cnt_d = job_q.left ? pad_q[6:0] : 7'd0;
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (cnt_q != '0) begin
          ch = ChSpace; ch_v = 1'b1;
          if (can_emit) cnt_d = cnt_q - 7'd1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (can_emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (ch_v && can_emit) begin
      emit_d = emit_q + 7'd1;
      // Drop the rest once the cap is reached.
      if (emit_d == 7'(MAX_CHARS)) state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      obuf_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (can_emit) obuf_v_q <= ch_v || (state_q == ST_BAD);
    end
  end

  always_ff @(posedge clk_i) begin
    nd_q <= nd_d; quo_q <= quo_d; rem_q <= rem_d; bit_q <= bit_d;
    pad_q <= pad_d; cnt_q <= cnt_d; emit_q <= emit_d; tot_q <= tot_d;
    if (take_job) job_q <= job_i;
    if (dig_we) begin
      digs_q[0] <= dig_val;
      for (int i = 1; i < MaxDigits; i++) digs_q[i] <= digs_q[i-1];
    end else if (dig_pop) begin
      for (int i = 0; i < MaxDigits - 1; i++) digs_q[i] <= digs_q[i+1];
    end
    if (can_emit) begin
      obuf_c_q <= (state_q == ST_BAD) ? 8'h00 : ch;
      obuf_b_q <= (state_q == ST_BAD);
      obuf_l_q <= (state_q == ST_BAD) || (emit_d == tot_q)
                  || (emit_d == 7'(MAX_CHARS));
      obuf_t_q <= (state_q != ST_BAD) && (emit_d == 7'(MAX_CHARS))
                  && (tot_q > 7'(MAX_CHARS));
    end
  end

  assign valid_o     = obuf_v_q;
  assign out_char_o  = obuf_c_q;
  assign last_o      = obuf_l_q;
  assign bad_base_o  = obuf_b_q;
  assign truncated_o = obuf_t_q;

endmodule

@@ src/itf_checker.sv @@
// ----------------------------------------------------------------------------
// itf_checker
// Port-level checks on the formatter's output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module itf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_o,
  input logic       ready_i,
  input logic [7:0] out_char_o,
  input logic       last_o,
  input logic       bad_base_o,
  input logic       truncated_o
);
  `ASSERT_IMPL(a_bad_last, clk_i, rst_ni, valid_o && bad_base_o |-> last_o && out_char_o == 8'h00, "bad base item not final")
  `ASSERT_IMPL(a_trunc_last, clk_i, rst_ni, valid_o && truncated_o |-> last_o && !bad_base_o, "truncated on non-final")
  `ASSERT_IMPL(a_hold, clk_i, rst_ni, valid_o && !ready_i |=> valid_o && $stable(out_char_o), "output dropped")
endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (
  .clk_i, .rst_ni, .valid_o, .ready_i, .out_char_o, .last_o, .bad_base_o,
  .truncated_o
);
